[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands; expect clk and arst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[sv/kps_pkg.sv]
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants for the knight shortest-path search.
// ----------------------------------------------------------------------------
package kps_pkg;

	localparam int NUM_MOVES   = 8;
	localparam int MAX_RESULTS = 7;

	typedef logic signed [2:0] delta_t;

	// knight moves in search order, file then rank delta
	localparam delta_t MOVE_DF [NUM_MOVES] = '{
		3'sd1, 3'sd1, -3'sd1, -3'sd1, 3'sd2, 3'sd2, -3'sd2, -3'sd2
	};
	localparam delta_t MOVE_DR [NUM_MOVES] = '{
		3'sd2, -3'sd2, 3'sd2, -3'sd2, 3'sd1, -3'sd1, 3'sd1, -3'sd1
	};

	typedef struct packed {
		logic [2:0] start_file;
		logic [2:0] start_rank;
		logic [2:0] goal_file;
		logic [2:0] goal_rank;
	} query_t;

	typedef struct packed {
		logic [2:0] square_file;
		logic [2:0] square_rank;
		logic       last_square;
	} square_t;

	typedef struct packed {
		logic init;
		logic deq;
		logic move;
		logic walk_init;
		logic walk_wr;
		logic walk_load;
		logic emit;
	} kps_cmd_t;

	typedef struct packed {
		logic on_board;
		logic q_empty;
		logic cur_is_goal;
		logic move_last;
		logic walk_at_start;
		logic emit_last;
		logic out_free;
	} kps_sts_t;

endpackage

[sv/kps_dpath.sv]
// ----------------------------------------------------------------------------
// kps_dpath
// Search datapath: visited map, BFS queue, parent store, path ring, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kps_dpath #(
	parameter int BOARD_SIZE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kps_pkg::query_t   query,
	input  kps_pkg::kps_cmd_t cmd,
	output kps_pkg::kps_sts_t sts,
	input  logic              out_stall,
	output logic              out_valid,
	output kps_pkg::square_t  out_data
);
	import kps_pkg::*;

	localparam int CW     = $clog2(BOARD_SIZE);
	localparam int SW     = 2 * CW;
	localparam int NSQ    = 2 ** SW;
	localparam int QDEPTH = BOARD_SIZE * BOARD_SIZE;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int PTRW   = QAW + 1;
	localparam int LW     = $clog2(QDEPTH + 1);
	localparam int MW     = $clog2(NUM_MOVES);
	localparam int RW     = $clog2(MAX_RESULTS + 1);
	localparam int PBD    = 2 ** RW;

	logic [SW-1:0]   queue_mem [QDEPTH];
	logic [SW-1:0]   parent_mem [NSQ];
	logic [SW-1:0]   path_buf [PBD];

	logic [NSQ-1:0]  visited_q;
	logic [PTRW-1:0] head_q, tail_q;
	logic [MW-1:0]   move_q;
	logic [LW-1:0]   len_q;
	logic [RW-1:0]   k_q;
	logic            out_valid_q;

	logic [SW-1:0]   start_q, goal_q, qdata_q, pdata_q, walk_q;
	square_t         out_q;

	logic [SW-1:0]   start_sq;
	logic            on_board;
	logic signed [CW+1:0] nf_s, nr_s;
	logic            in_bounds, enq;
	logic [SW-1:0]   ns;
	logic            q_we;
	logic [QAW-1:0]  q_waddr;
	logic [SW-1:0]   q_wdata;
	logic [RW-1:0]   n_res, rd_idx;
	logic [SW-1:0]   rd_sq;

	assign on_board = (int'(query.start_file) < BOARD_SIZE) &&
		(int'(query.start_rank) < BOARD_SIZE) &&
		(int'(query.goal_file) < BOARD_SIZE) &&
		(int'(query.goal_rank) < BOARD_SIZE);
	assign start_sq = {CW'(query.start_rank), CW'(query.start_file)};

	assign nf_s = $signed({2'b00, qdata_q[CW-1:0]}) + (CW+2)'(MOVE_DF[move_q]);
	assign nr_s = $signed({2'b00, qdata_q[SW-1:CW]}) + (CW+2)'(MOVE_DR[move_q]);
	assign in_bounds = (nf_s >= 0) && (nf_s < (CW+2)'(BOARD_SIZE)) &&
		(nr_s >= 0) && (nr_s < (CW+2)'(BOARD_SIZE));
	assign ns  = {nr_s[CW-1:0], nf_s[CW-1:0]};
	assign enq = cmd.move && in_bounds && !visited_q[ns];

	assign q_we    = cmd.init || enq;
	assign q_waddr = cmd.init ? '0 : tail_q[QAW-1:0];
	assign q_wdata = cmd.init ? start_sq : ns;

	assign n_res  = (len_q < LW'(MAX_RESULTS)) ? len_q[RW-1:0] : RW'(MAX_RESULTS);
	assign rd_idx = len_q[RW-1:0] - RW'(1) - k_q;
	assign rd_sq  = path_buf[rd_idx];

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
		if (cmd.deq) begin
			qdata_q <= queue_mem[head_q[QAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			parent_mem[ns] <= qdata_q;
		end
		if (cmd.walk_wr) begin
			pdata_q <= parent_mem[walk_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			move_q      <= '0;
			len_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				visited_q <= {{(NSQ-1){1'b0}}, 1'b1} << start_sq;
				head_q    <= '0;
				tail_q    <= PTRW'(1);
			end
			if (enq) begin
				visited_q[ns] <= 1'b1;
				tail_q        <= tail_q + PTRW'(1);
			end
			if (cmd.deq) begin
				head_q <= head_q + PTRW'(1);
				move_q <= '0;
			end
			if (cmd.move) begin
				move_q <= move_q + MW'(1);
			end
			if (cmd.walk_init) begin
				len_q <= '0;
				k_q   <= '0;
			end
			if (cmd.walk_wr) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.emit) begin
				k_q <= k_q + RW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			start_q <= start_sq;
			goal_q  <= {CW'(query.goal_rank), CW'(query.goal_file)};
		end
		if (cmd.walk_init) begin
			walk_q <= goal_q;
		end else if (cmd.walk_load) begin
			walk_q <= pdata_q;
		end
		if (cmd.walk_wr) begin
			path_buf[len_q[RW-1:0]] <= walk_q;
		end
		if (cmd.emit) begin
			out_q.square_file <= 3'(rd_sq[CW-1:0]);
			out_q.square_rank <= 3'(rd_sq[SW-1:CW]);
			out_q.last_square <= ((k_q + RW'(1)) == n_res);
		end
	end

	always_comb begin
		sts.on_board      = on_board;
		sts.q_empty       = (head_q == tail_q);
		sts.cur_is_goal   = (qdata_q == goal_q);
		sts.move_last     = (move_q == MW'(NUM_MOVES - 1));
		sts.walk_at_start = (walk_q == start_q);
		sts.emit_last     = ((k_q + RW'(1)) == n_res);
		sts.out_free      = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_CLK(a_tail_bound, tail_q <= PTRW'(QDEPTH), "queue tail past board size")
	`ASSERT_NEVER(a_head_past_tail, head_q > tail_q, "queue head overtook tail")
	`ASSERT_CLK(a_emit_free, cmd.emit |-> (!out_valid_q || !out_stall), "output overwritten")

endmodule

[sv/kps_ctrl.sv]
// ----------------------------------------------------------------------------
// kps_ctrl
// Sequencer: dequeue, move scan, parent walk-back and path emission.
// ----------------------------------------------------------------------------
module kps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_stall,
	input  kps_pkg::kps_sts_t sts,
	output kps_pkg::kps_cmd_t cmd
);
	import kps_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DEQ       = 3'd1;
	localparam logic [2:0] ST_MOVES     = 3'd2;
	localparam logic [2:0] ST_WALK_WR   = 3'd3;
	localparam logic [2:0] ST_WALK_WAIT = 3'd4;
	localparam logic [2:0] ST_EMIT      = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_valid && sts.on_board) begin
					cmd.init = 1'b1;
					state_d  = ST_DEQ;
				end
			end
			ST_DEQ: begin
				if (sts.q_empty) begin
					state_d = ST_IDLE;
				end else begin
					cmd.deq = 1'b1;
					state_d = ST_MOVES;
				end
			end
			ST_MOVES: begin
				if (sts.cur_is_goal) begin
					cmd.walk_init = 1'b1;
					state_d       = ST_WALK_WR;
				end else begin
					cmd.move = 1'b1;
					if (sts.move_last) begin
						state_d = ST_DEQ;
					end
				end
			end
			ST_WALK_WR: begin
				cmd.walk_wr = 1'b1;
				state_d     = sts.walk_at_start ? ST_EMIT : ST_WALK_WAIT;
			end
			ST_WALK_WAIT: begin
				cmd.walk_load = 1'b1;
				state_d       = ST_WALK_WR;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign query_stall = (state_q != ST_IDLE);

endmodule

[sv/knight_shortest_path_search.sv]
// ----------------------------------------------------------------------------
// knight_shortest_path_search
// Breadth-first knight path search with path walk-back and emission.
// ----------------------------------------------------------------------------
// Each query transfer carries a start and a goal square; the block answers
// with the shortest knight path from start to goal, one square per transfer,
// the goal flagged by last_square. Queries naming a square off the board give
// no result. A query dequeues each square in turn and tries its knight moves
// (eight per square expanded), then walks back through the parent store from
// the goal to the start and emits the path squares; the move scan tries one
// move a cycle against the visited map and the queue write port. The visited
// map clears at query start, so there is no clearing pass. query_stall stays
// high from acceptance until the last square is loaded into the output
// register, or until the queue runs empty with no path found.
module knight_shortest_path_search #(
	parameter int BOARD_SIZE = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_stall,
	input  kps_pkg::query_t  query,
	output logic             square_valid,
	input  logic             square_stall,
	output kps_pkg::square_t square
);
	import kps_pkg::*;

	kps_cmd_t cmd;
	kps_sts_t sts;

	kps_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_stall (query_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	kps_dpath #(
		.BOARD_SIZE (BOARD_SIZE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (square_stall),
		.out_valid (square_valid),
		.out_data  (square)
	);

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for knight_shortest_path_search: directed table of
// queries then random ones, each path tabled or predicted by an in-bench BFS
// and compared square by square, under varying sender idling and receiver stall.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kps_pkg::*;

	localparam int BOARD         = 8;
	localparam int CELLS         = BOARD * BOARD;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 50;
	localparam int RANDOM_PER_PHASE = 32;
	localparam int N_DIRECTED    = 22;

	typedef struct packed {
		query_t     q;
		logic [1:0] typed_len;
		square_t    first;
		square_t    second;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    query_valid = 1'b0;
	logic    query_stall;
	query_t  query = '0;
	logic    square_valid;
	logic    square_stall = 1'b0;
	square_t square;

	square_t expected_squares [$];
	int      mismatch_count = 0;
	int      quiet_cycles = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;

	// typed_len 0: path comes from the predictor
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{'{3'd0, 3'd0, 3'd0, 3'd0}, 2'd1, '{3'd0, 3'd0, 1'b1}, '0}, // A1 -> A1
		'{'{3'd7, 3'd7, 3'd7, 3'd7}, 2'd1, '{3'd7, 3'd7, 1'b1}, '0}, // H8 -> H8
		'{'{3'd3, 3'd3, 3'd4, 3'd5}, 2'd2, '{3'd3, 3'd3, 1'b0}, '{3'd4, 3'd5, 1'b1}},
		'{'{3'd3, 3'd3, 3'd4, 3'd1}, 2'd2, '{3'd3, 3'd3, 1'b0}, '{3'd4, 3'd1, 1'b1}},
		'{'{3'd3, 3'd3, 3'd2, 3'd5}, 2'd2, '{3'd3, 3'd3, 1'b0}, '{3'd2, 3'd5, 1'b1}},
		'{'{3'd3, 3'd3, 3'd2, 3'd1}, 2'd2, '{3'd3, 3'd3, 1'b0}, '{3'd2, 3'd1, 1'b1}},
		'{'{3'd3, 3'd3, 3'd5, 3'd4}, 2'd2, '{3'd3, 3'd3, 1'b0}, '{3'd5, 3'd4, 1'b1}},
		'{'{3'd3, 3'd3, 3'd5, 3'd2}, 2'd2, '{3'd3, 3'd3, 1'b0}, '{3'd5, 3'd2, 1'b1}},
		'{'{3'd3, 3'd3, 3'd1, 3'd4}, 2'd2, '{3'd3, 3'd3, 1'b0}, '{3'd1, 3'd4, 1'b1}},
		'{'{3'd3, 3'd3, 3'd1, 3'd2}, 2'd2, '{3'd3, 3'd3, 1'b0}, '{3'd1, 3'd2, 1'b1}},
		'{'{3'd0, 3'd0, 3'd1, 3'd2}, 2'd2, '{3'd0, 3'd0, 1'b0}, '{3'd1, 3'd2, 1'b1}},
		'{'{3'd7, 3'd7, 3'd6, 3'd5}, 2'd2, '{3'd7, 3'd7, 1'b0}, '{3'd6, 3'd5, 1'b1}},
		'{'{3'd0, 3'd0, 3'd7, 3'd7}, 2'd0, '0, '0}, // A1 -> H8, longest path
		'{'{3'd7, 3'd7, 3'd0, 3'd0}, 2'd0, '0, '0},
		'{'{3'd0, 3'd7, 3'd7, 3'd0}, 2'd0, '0, '0},
		'{'{3'd7, 3'd0, 3'd0, 3'd7}, 2'd0, '0, '0},
		'{'{3'd0, 3'd0, 3'd1, 3'd1}, 2'd0, '0, '0}, // corner diagonal
		'{'{3'd7, 3'd7, 3'd6, 3'd6}, 2'd0, '0, '0},
		'{'{3'd0, 3'd0, 3'd0, 3'd1}, 2'd0, '0, '0},
		'{'{3'd4, 3'd4, 3'd3, 3'd3}, 2'd0, '0, '0},
		'{'{3'd5, 3'd2, 3'd2, 3'd5}, 2'd0, '0, '0},
		'{'{3'd2, 3'd5, 3'd5, 3'd2}, 2'd0, '0, '0}
	};

	knight_shortest_path_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.square_valid (square_valid),
		.square_stall (square_stall),
		.square       (square)
	);

	always #5 clk = ~clk;

	// breadth-first search, moves tried in package order, first discovery wins
	function automatic void predict_knight_path(input query_t q);
		bit         seen [CELLS];
		bit         has_parent [CELLS];
		logic [5:0] parent [CELLS];
		logic [5:0] frontier [CELLS];
		logic [5:0] trail [CELLS];
		logic [5:0] start_sq, goal_sq, here, next_sq;
		int         head, tail, len, count, nf, nr;
		square_t    s;
		start_sq = {q.start_rank, q.start_file};
		goal_sq  = {q.goal_rank, q.goal_file};
		for (int i = 0; i < CELLS; i++) begin
			seen[i] = 1'b0;
			has_parent[i] = 1'b0;
			parent[i] = '0;
		end
		head = 0;
		tail = 1;
		frontier[0] = start_sq;
		seen[start_sq] = 1'b1;
		while (head < tail) begin
			here = frontier[head];
			head++;
			if (here == goal_sq)
				break;
			for (int m = 0; m < NUM_MOVES; m++) begin
				nf = int'(here[2:0]) + int'(MOVE_DF[m]);
				nr = int'(here[5:3]) + int'(MOVE_DR[m]);
				if (nf < 0 || nf >= BOARD || nr < 0 || nr >= BOARD)
					continue;
				next_sq = 6'(nr * BOARD + nf);
				if (seen[next_sq])
					continue;
				if (tail < CELLS) begin
					frontier[tail] = next_sq;
					tail++;
				end
				seen[next_sq] = 1'b1;
				has_parent[next_sq] = 1'b1;
				parent[next_sq] = here;
			end
		end
		if (!seen[goal_sq])
			return;
		len = 0;
		here = goal_sq;
		while (len < CELLS) begin
			trail[len] = here;
			len++;
			if (!has_parent[here])
				break;
			here = parent[here];
		end
		count = (len < MAX_RESULTS) ? len : MAX_RESULTS;
		for (int k = 0; k < count; k++) begin
			s.square_file = trail[len - 1 - k][2:0];
			s.square_rank = trail[len - 1 - k][5:3];
			s.last_square = (k + 1 == count);
			expected_squares.insert(expected_squares.size(), s);
		end
	endfunction

	task automatic send_query(input stim_row_t row);
		while ($urandom_range(99) < idle_pct) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query <= row.q;
		do @(posedge clk); while (query_stall);
		if (row.typed_len == 2'd0) begin
			predict_knight_path(row.q);
		end else begin
			expected_squares.insert(expected_squares.size(), row.first);
			if (row.typed_len == 2'd2)
				expected_squares.insert(expected_squares.size(), row.second);
		end
	endtask

	always @(posedge clk) begin
		square_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		square_t want;
		if (arst_n) begin
			if ((query_valid && !query_stall) || (square_valid && !square_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (square_valid && !square_stall) begin
				if (expected_squares.size() == 0) begin
					$display("%0t: unexpected square expected none got %0d/%0d/%0d", $time,
						square.square_file, square.square_rank, square.last_square);
					mismatch_count++;
				end else begin
					want = expected_squares.pop_front();
					if (square.square_file !== want.square_file) begin
						$display("%0t: square_file expected %0d got %0d", $time,
							want.square_file, square.square_file);
						mismatch_count++;
					end
					if (square.square_rank !== want.square_rank) begin
						$display("%0t: square_rank expected %0d got %0d", $time,
							want.square_rank, square.square_rank);
						mismatch_count++;
					end
					if (square.last_square !== want.last_square) begin
						$display("%0t: last_square expected %0d got %0d", $time,
							want.last_square, square.last_square);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		stim_row_t row;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i])
			send_query(directed_rows[i]);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				row = '0;
				row.q.start_file = 3'($urandom_range(7));
				row.q.start_rank = 3'($urandom_range(7));
				row.q.goal_file  = 3'($urandom_range(7));
				row.q.goal_rank  = 3'($urandom_range(7));
				if ($urandom_range(9) == 0) begin
					row.q.goal_file = row.q.start_file;
					row.q.goal_rank = row.q.start_rank;
				end
				send_query(row);
			end
		end
		query_valid <= 1'b0;
		while (expected_squares.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/kps_pkg.sv
sv/kps_dpath.sv
sv/kps_ctrl.sv
sv/knight_shortest_path_search.sv
verif/tb.sv
